// File: rtl/bbcd_pkg.sv
// Package for the byte budget cache directory: codes, widths and word types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package bbcd_pkg;

  localparam int Entries = 32;
  localparam int SlotW = 5;

  localparam logic [27:0] CapReset = 28'd209715200;
  localparam logic [27:0] MaxReset = 28'd10485760;

  localparam logic [1:0] PolLru = 2'd0;
  localparam logic [1:0] PolFifo = 2'd1;
  localparam logic [1:0] PolLfu = 2'd2;

  localparam logic [1:0] RegPolicy = 2'd0;
  localparam logic [1:0] RegCapacity = 2'd1;
  localparam logic [1:0] RegMaxEntry = 2'd2;

  localparam logic [2:0] KindHit = 3'd0;
  localparam logic [2:0] KindMiss = 3'd1;
  localparam logic [2:0] KindEvict = 3'd2;
  localparam logic [2:0] KindInsert = 3'd3;
  localparam logic [2:0] KindReject = 3'd4;

  // One directory entry as held in the entry memory.
  typedef struct packed {
    logic [63:0] key;
    logic [27:0] size;
    logic [31:0] last_use;
    logic [31:0] insert_time;
    logic [31:0] use_count;
    logic [31:0] insert_order;
  } entry_t;

  // Write request into the entry memory.
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // One result word.
  typedef struct packed {
    logic             last;
    logic [27:0]      bytes_in_use;
    logic [63:0]      victim_key;
    logic [SlotW-1:0] slot;
    logic [2:0]       kind;
  } result_t;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanLast,
    StDecide,
    StEvictRd,
    StEvictWait,
    StEvictOut,
    StHitWait,
    StWrite,
    StOut
  } state_t;

endpackage

// File: rtl/byte_budget_cache_directory.sv
// Byte budget cache directory with LRU, FIFO or LFU replacement.
// Every word scans all 32 slots, one entry memory read per slot, before the decision and output;
// a hit also re-reads and rewrites its entry to refresh its last use and use count.
// Each eviction adds a victim read, an eviction word and a rescan of all slots.
// One item at a time; the next word is taken the cycle after the last result is issued.
// Synchronous active-high reset clears valid bits and counters and returns configuration to its reset values.
`timescale 1ns / 1ps
module byte_budget_cache_directory
  import bbcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // key[63:0], entry_bytes[91:64], now[123:92]
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // slot[4:0], victim_key[68:5], bytes_in_use[96:69]
  output logic [2:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [27:0]  cfg_data
);

  logic [1:0]       policy;
  logic [27:0]      capacity_bytes;
  logic [27:0]      max_entry_bytes;
  logic             idle;
  result_t          res;
  mem_wr_t          wr;
  logic [SlotW-1:0] rd_addr;
  entry_t           rd_data;

  assign cfg_ready = 1'b1;

  bbcd_cfg u_cfg (
    .clk, .rst,
    .wvalid(cfg_valid), .windex(cfg_index), .wdata(cfg_data),
    .policy, .capacity_bytes, .max_entry_bytes
  );

  bbcd_entry_ram u_ram (.clk, .wr, .rd_addr, .rd_data);

  bbcd_ctrl u_ctrl (
    .clk, .rst, .policy, .capacity_bytes, .max_entry_bytes,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_action(s_axis_tuser), .in_key(s_axis_tdata[63:0]),
    .in_bytes(s_axis_tdata[91:64]), .in_now(s_axis_tdata[123:92]),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res,
    .idle, .wr, .rd_addr, .rd_data
  );

  // Output word packing.
  assign m_axis_tdata = {7'd0, res.bytes_in_use, res.victim_key, res.slot};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // The user must write configuration only while the block is idle; the block does not enforce it.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> idle)
    else $error("configuration written while busy");

  // A stalled result word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // Result kinds stay within the defined codes.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= KindReject)
    else $error("result kind out of range");

  // Evictions never carry last.
  a_evict_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KindEvict |-> !m_axis_tlast)
    else $error("eviction marked last");

endmodule

// File: rtl/bbcd_entry_ram.sv
// Entry memory of the directory: one write port and one registered read port.
// Depends on bbcd_pkg for the entry layout.
`timescale 1ns / 1ps
module bbcd_entry_ram
  import bbcd_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [SlotW-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [Entries];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/bbcd_ctrl.sv
// Sequencer: scans the entry memory for a hit or a victim, evicts and inserts.
// Depends on bbcd_pkg and drives bbcd_entry_ram through its ports.
`timescale 1ns / 1ps
module bbcd_ctrl
  import bbcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       policy,
  input  logic [27:0]      capacity_bytes,
  input  logic [27:0]      max_entry_bytes,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [63:0]      in_key,
  input  logic [27:0]      in_bytes,
  input  logic [31:0]      in_now,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             idle,
  output mem_wr_t          wr,
  output logic [SlotW-1:0] rd_addr,
  input  entry_t           rd_data
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(Entries - 1);

  state_t state, state_next;

  logic              action;
  logic [63:0]       key;
  logic [27:0]       size;
  logic [31:0]       now;
  logic [Entries-1:0] valid;
  logic [31:0]       insert_sequence;
  logic [27:0]       used_bytes;

  // Scan bookkeeping: address issued, address whose data returns now.
  logic [SlotW-1:0]  scan_addr;
  logic [SlotW-1:0]  data_addr;
  logic              found;
  logic [SlotW-1:0]  best;
  logic [31:0]       best_rank;
  logic [31:0]       best_age;
  logic [SlotW-1:0]  evict_count;
  logic              evict_lim;

  // Rank of the entry returning from memory under the chosen rule.
  logic [31:0] rank;
  logic [31:0] age;
  logic        better;
  logic        cand;
  always_comb begin
    case (policy)
      PolFifo: rank = rd_data.insert_time;
      PolLfu:  rank = rd_data.use_count;
      default: rank = rd_data.last_use;
    endcase
    age = insert_sequence - rd_data.insert_order;
    if (action) begin
      cand = valid[data_addr];
      better = !found || rank < best_rank || (rank == best_rank && age < best_age);
    end else begin
      cand = valid[data_addr] && rd_data.key == key;
      better = !found || age < best_age;
    end
  end

  // Free slot search and budget check.
  logic             has_free;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end
  logic over;
  assign over = ({1'b0, used_bytes} + {1'b0, size}) > {1'b0, capacity_bytes};
  logic [27:0] freed;
  assign freed = (used_bytes >= rd_data.size) ? used_bytes - rd_data.size : '0;

  assign in_ready = (state == StIdle);
  assign idle = (state == StIdle) && !res_valid;

  // Next state and memory addressing.
  always_comb begin
    state_next = state;
    rd_addr = scan_addr;
    unique case (state)
      StIdle:      if (in_valid) state_next = StScan;
      StScan:      if (scan_addr == LastSlot) state_next = StScanLast;
      StScanLast:  state_next = StDecide;
      StDecide:    state_next = StIdle;
      StEvictRd:   begin rd_addr = best; state_next = StEvictWait; end
      StEvictWait: state_next = StEvictOut;
      StEvictOut:  if (!res_valid || res_ready) state_next = StIdle;
      StHitWait:   state_next = StWrite;
      StWrite:     state_next = StOut;
      StOut:       if (!res_valid || res_ready) state_next = StIdle;
      default:     state_next = StIdle;
    endcase
    if (state == StDecide) begin
      if (!action) begin
        rd_addr = best;
        state_next = found ? StHitWait : StOut;
      end else if (size > max_entry_bytes || size > capacity_bytes) begin
        state_next = StOut;
      end else if ((over || !has_free) && found && !evict_lim) begin
        state_next = StEvictRd;
      end else begin
        state_next = StOut;
      end
    end
    if (state == StEvictOut && (!res_valid || res_ready)) state_next = StScan;
    // Keep the victim or hit entry on the read port while it is used.
    if (state == StHitWait || state == StWrite || state == StEvictWait ||
        state == StEvictOut) rd_addr = best;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else state <= state_next;
  end

  // Fill is allowed when the result slot is open, room exists and the size is within both limits.
  function automatic logic res_ready_fill();
    return (!res_valid || res_ready) && has_free && !over &&
           !(size > max_entry_bytes || size > capacity_bytes);
  endfunction

  // Entry write for a hit refresh or a fill.
  always_comb begin
    wr = '0;
    if (state == StWrite) begin
      wr.en = 1'b1;
      wr.addr = best;
      wr.data = rd_data;
      wr.data.last_use = now;
      if (rd_data.use_count != 32'hFFFF_FFFF) wr.data.use_count = rd_data.use_count + 32'd1;
    end else if (state == StOut && action && res_ready_fill()) begin
      wr.en = 1'b1;
      wr.addr = free_idx;
      wr.data.key = key;
      wr.data.size = size;
      wr.data.last_use = now;
      wr.data.insert_time = now;
      wr.data.use_count = 32'd1;
      wr.data.insert_order = insert_sequence;
    end
  end

  logic out_fire;
  assign out_fire = (state == StOut || state == StEvictOut) && (!res_valid || res_ready);

  // Datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      insert_sequence <= '0;
      used_bytes <= '0;
      res_valid <= 1'b0;
    end else begin
      if (out_fire) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (state == StEvictOut && out_fire) begin
        valid[best] <= 1'b0;
        used_bytes <= freed;
        res.kind <= KindEvict;
        res.slot <= best;
        res.victim_key <= rd_data.key;
        res.bytes_in_use <= freed;
        res.last <= 1'b0;
      end
      if (state == StOut && out_fire) begin
        res.victim_key <= '0;
        res.last <= 1'b1;
        if (!action) begin
          res.kind <= found ? KindHit : KindMiss;
          res.slot <= found ? best : '0;
          res.bytes_in_use <= used_bytes;
        end else if (res_ready_fill()) begin
          valid[free_idx] <= 1'b1;
          insert_sequence <= insert_sequence + 32'd1;
          used_bytes <= used_bytes + size;
          res.kind <= KindInsert;
          res.slot <= free_idx;
          res.bytes_in_use <= used_bytes + size;
        end else begin
          res.kind <= KindReject;
          res.slot <= '0;
          res.bytes_in_use <= used_bytes;
        end
      end
    end
  end

  // Scan and request registers.
  always_ff @(posedge clk) begin
    data_addr <= scan_addr;
    if (state == StIdle && in_valid) begin
      action <= in_action;
      key <= in_key;
      size <= in_bytes;
      now <= in_now;
      evict_count <= '0;
      evict_lim <= 1'b0;
    end
    if ((state == StIdle && in_valid) || (state == StEvictOut && out_fire)) begin
      scan_addr <= '0;
      found <= 1'b0;
    end
    if (state == StEvictOut && out_fire) begin
      evict_count <= evict_count + 1'b1;
      evict_lim <= (evict_count == LastSlot);
    end
    if (state == StScan) scan_addr <= scan_addr + 1'b1;
    if ((state == StScan && scan_addr != '0) || state == StScanLast) begin
      if (cand && better) begin
        found <= 1'b1;
        best <= data_addr;
        best_rank <= rank;
        best_age <= age;
      end
    end
  end

endmodule

// File: rtl/bbcd_cfg.sv
// Configuration register file: policy, capacity and per-entry byte limit.
// Depends on bbcd_pkg for register indexes and reset values.
`timescale 1ns / 1ps
module bbcd_cfg
  import bbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wvalid,
  input  logic [1:0]  windex,
  input  logic [27:0] wdata,
  output logic [1:0]  policy,
  output logic [27:0] capacity_bytes,
  output logic [27:0] max_entry_bytes
);

  // Register writes decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= PolLru;
      capacity_bytes <= CapReset;
      max_entry_bytes <= MaxReset;
    end else if (wvalid) begin
      unique case (windex)
        RegPolicy:   policy <= wdata[1:0];
        RegCapacity: capacity_bytes <= wdata;
        RegMaxEntry: max_entry_bytes <= wdata;
        default:     ;
      endcase
    end
  end

endmodule

// File: bench/byte_budget_cache_directory_test.sv
// Testbench for the byte budget cache directory: directed and random lookups and inserts,
// checked against a predictor of the directory. Depends on bbcd_pkg and the block's RTL.
`timescale 1ns / 1ps
module byte_budget_cache_directory_test;
  import bbcd_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam logic [1:0] PolSpare = 2'd3;
  localparam logic [27:0] Max28 = 28'hFFFFFFF;
  localparam bit ActLookup = 1'b0;
  localparam bit ActInsert = 1'b1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [27:0]  cfg_data = '0;

  byte_budget_cache_directory DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted directory contents and configuration.
  logic [1:0]  dir_policy;
  logic [27:0] dir_capacity, dir_max_entry;
  bit          dir_valid [Entries];
  logic [63:0] dir_key [Entries];
  logic [27:0] dir_size [Entries];
  logic [31:0] dir_last_use [Entries];
  logic [31:0] dir_insert_time [Entries];
  logic [31:0] dir_use_count [Entries];
  logic [31:0] dir_order [Entries];
  logic [31:0] dir_sequence;
  logic [27:0] dir_used;

  result_t pending_results [$];
  int      error_count = 0;
  int      words_sent = 0;
  int      words_checked = 0;
  int      evictions_seen = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;
  logic [63:0] key_pool [12];
  logic [31:0] clock_stamp = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] victim_rank(int i);
    if (dir_policy == PolFifo) return dir_insert_time[i];
    if (dir_policy == PolLfu) return dir_use_count[i];
    return dir_last_use[i];
  endfunction

  // Lowest rank wins; ties go to the most recent insert.
  function automatic int choose_victim();
    int best;
    logic [31:0] ri, rb, ai, ab;
    best = -1;
    for (int i = 0; i < Entries; i++) begin
      if (!dir_valid[i]) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      ri = victim_rank(i);
      rb = victim_rank(best);
      ai = dir_sequence - dir_order[i];
      ab = dir_sequence - dir_order[best];
      if (ri < rb || (ri == rb && ai < ab)) best = i;
    end
    return best;
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < Entries; i++) if (!dir_valid[i]) return i;
    return -1;
  endfunction

  function automatic result_t make_result(logic [2:0] kind, int slot, logic [63:0] vkey);
    result_t r;
    r.kind = kind;
    r.slot = slot[SlotW-1:0];
    r.victim_key = vkey;
    r.bytes_in_use = dir_used;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted word and update the predicted directory.
  task automatic predict_directory(bit act, logic [63:0] key, logic [27:0] sz, logic [31:0] now);
    result_t outs [$];
    int hit, v, s, guard;
    logic [31:0] a_i, a_h;
    hit = -1;
    guard = 0;
    if (act == ActLookup) begin
      for (int i = 0; i < Entries; i++) begin
        if (!dir_valid[i] || dir_key[i] != key) continue;
        a_i = dir_sequence - dir_order[i];
        a_h = (hit < 0) ? 32'd0 : dir_sequence - dir_order[hit];
        if (hit < 0 || a_i < a_h) hit = i;
      end
      if (hit >= 0) begin
        dir_last_use[hit] = now;
        if (dir_use_count[hit] != 32'hFFFFFFFF) dir_use_count[hit]++;
        outs.push_back(make_result(KindHit, hit, '0));
      end else begin
        outs.push_back(make_result(KindMiss, 0, '0));
      end
    end else if (sz > dir_max_entry || sz > dir_capacity) begin
      outs.push_back(make_result(KindReject, 0, '0));
    end else begin
      while (guard < Entries && (32'(dir_used) + 32'(sz) > 32'(dir_capacity) ||
                                 lowest_free_slot() < 0)) begin
        v = choose_victim();
        if (v < 0) break;
        dir_valid[v] = 1'b0;
        dir_used = (dir_used >= dir_size[v]) ? dir_used - dir_size[v] : '0;
        outs.push_back(make_result(KindEvict, v, dir_key[v]));
        guard++;
      end
      s = lowest_free_slot();
      if (s < 0 || 32'(dir_used) + 32'(sz) > 32'(dir_capacity)) begin
        outs.push_back(make_result(KindReject, 0, '0));
      end else begin
        dir_valid[s] = 1'b1;
        dir_key[s] = key;
        dir_size[s] = sz;
        dir_last_use[s] = now;
        dir_insert_time[s] = now;
        dir_use_count[s] = 32'd1;
        dir_order[s] = dir_sequence;
        dir_sequence++;
        dir_used = dir_used + sz;
        outs.push_back(make_result(KindInsert, s, '0));
      end
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) pending_results.push_back(outs[i]);
  endtask

  // Send one request word; valid stays high for a following word unless a gap is drawn.
  task automatic send_request(bit act, logic [63:0] key, logic [27:0] sz, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = {4'b0, now, sz, key};
    do @(posedge clk); while (!s_axis_tready);
    predict_directory(act, key, sz, now);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [27:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegPolicy: dir_policy = val[1:0];
      RegCapacity: dir_capacity = val;
      RegMaxEntry: dir_max_entry = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(logic [1:0] pol, logic [27:0] cap, logic [27:0] max_entry);
    wait_drained();
    write_register(RegPolicy, {26'b0, pol});
    write_register(RegCapacity, cap);
    write_register(RegMaxEntry, max_entry);
  endtask

  // Reset values: default budget and limit, empty directory.
  task automatic test_reset_defaults();
    send_request(ActLookup, 64'h0, 28'h0, 32'h0);
    send_request(ActInsert, 64'h0, 28'h0, 32'h0);
    send_request(ActInsert, 64'h5, MaxReset, 32'h10);
    send_request(ActInsert, 64'h6, MaxReset + 28'd1, 32'h11);
    send_request(ActLookup, 64'h5, Max28, 32'h12);
    send_request(ActLookup, 64'h0, 28'h0, 32'hFFFFFFFF);
  endtask

  // Extremes of the budget and of the entry size.
  task automatic test_budget_extremes();
    configure(PolLru, Max28, Max28);
    send_request(ActInsert, 64'hFFFFFFFFFFFFFFFF, Max28, 32'hFFFFFFFF);
    send_request(ActLookup, 64'hFFFFFFFFFFFFFFFF, 28'h0, 32'h20);
    configure(PolFifo, 28'd1, 28'd1);
    send_request(ActInsert, 64'hA5A5A5A5A5A5A5A5, 28'd1, 32'h21);
    send_request(ActInsert, 64'h5A5A5A5A5A5A5A5A, 28'd1, 32'h22);
    send_request(ActInsert, 64'h7, 28'd2, 32'h23);
  endtask

  // Each victim rule, including the unused code, with duplicate keys.
  task automatic test_policies();
    logic [1:0] pols [4];
    pols = '{PolLru, PolFifo, PolLfu, PolSpare};
    foreach (pols[p]) begin
      configure(pols[p], 28'd100, 28'd100);
      send_request(ActInsert, 64'h100 + p, 28'd40, 32'h30);
      send_request(ActInsert, 64'h100 + p, 28'd40, 32'h31);
      send_request(ActLookup, 64'h100 + p, 28'd0, 32'h32);
      send_request(ActInsert, 64'h200 + p, 28'd60, 32'h33);
    end
  endtask

  task automatic run_random(int count, int s_idle, int r_idle, int hold);
    bit act;
    logic [63:0] key;
    logic [27:0] sz, cap;
    logic [1:0] pol;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int part = 0; part < 2; part++) begin
      pol = 2'($urandom_range(3));
      cap = ($urandom_range(2) == 0) ? Max28 : 28'($urandom_range(300, 3000));
      configure(pol, cap, ($urandom_range(3) == 0) ? 28'($urandom_range(1, 800)) : Max28);
      if (part == 0) hold_cycles = hold;
      for (int n = 0; n < count / 2; n++) begin
        act = ($urandom_range(99) < 55);
        key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(11)];
        if ($urandom_range(9) == 0) sz = 28'($urandom);
        else sz = 28'($urandom_range(0, 700));
        clock_stamp += $urandom_range(0, 3);
        send_request(act, key, sz, ($urandom_range(19) == 0) ? $urandom : clock_stamp);
      end
    end
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {61'b0, m_axis_tuser}, 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
        if (m_axis_tdata[4:0] !== want.slot)
          report_mismatch("slot", 64'(m_axis_tdata[4:0]), 64'(want.slot));
        if (m_axis_tdata[68:5] !== want.victim_key)
          report_mismatch("victim_key", m_axis_tdata[68:5], want.victim_key);
        if (m_axis_tdata[96:69] !== want.bytes_in_use)
          report_mismatch("bytes_in_use", 64'(m_axis_tdata[96:69]), 64'(want.bytes_in_use));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        if (want.kind == KindEvict) evictions_seen++;
        words_checked++;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    dir_policy = PolLru;
    dir_capacity = CapReset;
    dir_max_entry = MaxReset;
    dir_sequence = '0;
    dir_used = '0;
    foreach (dir_valid[i]) dir_valid[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_budget_extremes();
    test_policies();
    run_random(48, 18, 45, 0);
    run_random(48, 45, 18, 0);
    run_random(48, 0, 0, 400);
    wait_drained();
    repeat (100) @(negedge clk);
    $display("Sent %0d requests, checked %0d results including %0d evictions,",
             words_sent, words_checked, evictions_seen);
    $display("over all victim rules, budget extremes and a long receiver hold-off.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
